>>> rtl/sggf_pkg.sv
// Shared types, constants and codes for the gripper grasp sequencer.
`default_nettype none

package sggf_pkg;

    // Force sample width and the width used to compare it with the limit
    localparam int PRESSURE_BITS = 10;
    localparam int LIMIT_BITS    = 10;
    localparam int PRESS_CMP_W   = (PRESSURE_BITS > LIMIT_BITS) ? PRESSURE_BITS : LIMIT_BITS;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESSURE_LIMIT = 2'd0,
        CFG_HOLD_WAIT_MS   = 2'd1,
        CFG_OPEN_ANGLE     = 2'd2,
        CFG_CLOSE_LIMIT    = 2'd3
    } cfg_idx_t;

    // Register reset values
    localparam logic [LIMIT_BITS-1:0] PRESSURE_LIMIT_RST = LIMIT_BITS'(512);
    localparam logic [15:0]           HOLD_WAIT_MS_RST   = 16'd8000;
    localparam logic [7:0]            OPEN_ANGLE_RST     = 8'd180;
    localparam logic [7:0]            CLOSE_LIMIT_RST    = 8'd100;
    localparam logic [7:0]            ANGLE_RST          = 8'd120;
    localparam logic [7:0]            ANGLE_MAX          = 8'd255;

    // Host command codes; all others mean no command
    localparam logic [2:0] CMD_GRIP    = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_RESET   = 3'd3;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_IDLE  = 3'd1,
        MODE_CLOSE = 3'd2,
        MODE_HOLD  = 3'd3,
        MODE_POPEN = 3'd4,
        MODE_END   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_INIT     = 2'd1,
        EV_GRIPPED  = 2'd2,
        EV_PLACED   = 2'd3
    } event_t;

    typedef struct packed {
        logic [PRESSURE_BITS-1:0] pressure;
        logic [2:0]               command;
        logic [31:0]              now_ms;
    } in_item_t;

    typedef struct packed {
        logic [7:0] servo_angle;
        logic       servo_write;
        mode_t      mode;
        event_t     event_res;
    } out_item_t;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] pressure_limit;
        logic [15:0]           hold_wait_ms;
        logic [7:0]            open_angle;
        logic [7:0]            close_limit;
    } cfg_t;

    // Handshake between the pipeline stages
    typedef struct packed {
        logic item_valid;   // input register holds an item
        logic advance;      // result register can take a new item
    } step_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/sggf_cfg.sv
// Configuration registers of the gripper grasp sequencer.
`default_nettype none

module sggf_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sggf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sggf_pkg::CFG_W-1:0]     cfg_data,
    output sggf_pkg::cfg_t                      cfg
);
    import sggf_pkg::*;

    cfg_t cfg_reg;

    // Register writes, truncated to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressure_limit <= PRESSURE_LIMIT_RST;
            cfg_reg.hold_wait_ms   <= HOLD_WAIT_MS_RST;
            cfg_reg.open_angle     <= OPEN_ANGLE_RST;
            cfg_reg.close_limit    <= CLOSE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRESSURE_LIMIT: cfg_reg.pressure_limit <= cfg_data[LIMIT_BITS-1:0];
                CFG_HOLD_WAIT_MS:   cfg_reg.hold_wait_ms   <= cfg_data[15:0];
                CFG_OPEN_ANGLE:     cfg_reg.open_angle     <= cfg_data[7:0];
                CFG_CLOSE_LIMIT:    cfg_reg.close_limit    <= cfg_data[7:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/sggf_in_stage.sv
// Input register of the gripper grasp sequencer.
`default_nettype none

module sggf_in_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire sggf_pkg::in_item_t  in_data,
    input  wire logic                advance,
    output sggf_pkg::step_ctrl_t     ctrl,
    output sggf_pkg::in_item_t       item
);
    import sggf_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Hold the item while the result side cannot move
    assign in_stall = valid_reg & ~advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_data;
        end
    end

    assign ctrl.item_valid = valid_reg;
    assign ctrl.advance    = advance;
    assign item            = item_reg;

endmodule

`default_nettype wire

>>> rtl/sggf_core.sv
// Mode sequencer: state registers and the per-step next-state logic.
`default_nettype none

module sggf_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sggf_pkg::step_ctrl_t ctrl,
    input  wire sggf_pkg::in_item_t   item,
    input  wire sggf_pkg::cfg_t       cfg,
    output sggf_pkg::out_item_t    result
);
    import sggf_pkg::*;

    mode_t       mode_reg,         mode_next;
    logic [7:0]  angle_reg,        angle_next;
    logic        contact_seen_reg, contact_seen_next;
    logic [31:0] contact_time_reg, contact_time_next;
    logic        contact_flag_next;

    logic                   step_en;
    logic [PRESS_CMP_W-1:0] press_cmp;
    logic [PRESS_CMP_W-1:0] limit_cmp;
    logic                   firm;
    logic                   press_zero;
    logic [8:0]             floor_9;
    logic [7:0]             clamp_angle;
    logic [7:0]             dec_angle;
    logic [8:0]             inc_9;
    logic [7:0]             inc_sat;
    logic                   dec_ok;
    logic [31:0]            deadline;
    logic                   hold_done;

    assign step_en = ctrl.item_valid & ctrl.advance;

    // Shared arithmetic for the step
    assign press_cmp   = PRESS_CMP_W'(item.pressure);
    assign limit_cmp   = PRESS_CMP_W'(cfg.pressure_limit);
    assign firm        = press_cmp >= limit_cmp;
    assign press_zero  = (item.pressure == '0);
    assign floor_9     = {1'b0, cfg.close_limit} + 9'd1;
    assign clamp_angle = (cfg.close_limit == ANGLE_MAX) ? ANGLE_MAX : floor_9[7:0];
    assign dec_angle   = angle_reg - 8'd1;
    // angle - 1 above the floor, i.e. angle above floor + 1
    assign dec_ok      = {1'b0, angle_reg} > floor_9;
    assign inc_9       = {1'b0, angle_reg} + 9'd1;
    assign inc_sat     = inc_9[8] ? ANGLE_MAX : inc_9[7:0];

    // Contact time as it stands after this step's latch, then the hold timer
    always_comb
    begin
        contact_time_next = contact_time_reg;
        contact_seen_next = contact_seen_reg;
        if (mode_reg == MODE_CLOSE && firm && !contact_seen_reg)
        begin
            contact_time_next = item.now_ms;
            contact_seen_next = 1'b1;
        end
    end

    assign deadline  = contact_time_next + {16'd0, cfg.hold_wait_ms};
    assign hold_done = item.now_ms > deadline;

    // Next mode, angle and result
    always_comb
    begin
        logic       seen_out;
        mode_next          = mode_reg;
        angle_next         = angle_reg;
        seen_out           = contact_seen_next;
        result.servo_write = 1'b0;
        result.event_res   = EV_NONE;
        result.servo_angle = angle_reg;

        unique case (mode_reg)
            MODE_INIT:
            begin
                if (angle_reg < cfg.open_angle)
                begin
                    result.servo_write = 1'b1;
                    result.servo_angle = angle_reg;
                    angle_next         = inc_sat;
                end
                else
                begin
                    result.event_res = EV_INIT;
                    mode_next        = MODE_IDLE;
                end
            end
            MODE_IDLE:
            begin
                if (item.command == CMD_GRIP)
                begin
                    mode_next = MODE_CLOSE;
                end
            end
            MODE_CLOSE:
            begin
                if (!firm && dec_ok)
                begin
                    angle_next         = dec_angle;
                    result.servo_write = 1'b1;
                    result.servo_angle = dec_angle;
                end
                else
                begin
                    if (hold_done)
                    begin
                        result.event_res = EV_GRIPPED;
                        mode_next        = MODE_HOLD;
                        seen_out         = 1'b0;
                    end
                    angle_next         = dec_ok ? dec_angle : clamp_angle;
                    result.servo_angle = angle_next;
                end
            end
            MODE_HOLD:
            begin
                if (item.command == CMD_RELEASE)
                begin
                    mode_next = MODE_POPEN;
                end
                else if (press_zero)
                begin
                    mode_next = MODE_END;
                end
            end
            MODE_POPEN:
            begin
                angle_next         = inc_sat;
                result.servo_angle = inc_sat;
                if (!press_zero && inc_9 < {1'b0, cfg.open_angle})
                begin
                    result.servo_write = 1'b1;
                end
                else
                begin
                    result.event_res = EV_PLACED;
                    mode_next        = MODE_END;
                end
            end
            MODE_END:
            begin
                if (item.command == CMD_RESET)
                begin
                    mode_next = MODE_INIT;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        result.mode = mode_next;
        contact_flag_next = seen_out;
    end

    // State registers, updated once per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_INIT;
            angle_reg        <= ANGLE_RST;
            contact_seen_reg <= 1'b0;
            contact_time_reg <= '0;
        end
        else if (step_en)
        begin
            mode_reg         <= mode_next;
            angle_reg        <= angle_next;
            contact_seen_reg <= contact_flag_next;
            contact_time_reg <= contact_time_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sggf_out_stage.sv
// Result register of the gripper grasp sequencer.
`default_nettype none

module sggf_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire sggf_pkg::out_item_t result,
    output logic                   advance,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sggf_pkg::out_item_t    out_data
);
    import sggf_pkg::*;

    logic      valid_reg;
    out_item_t data_reg;

    // Take a new result when empty or when the held one transfers
    assign advance = ~valid_reg | ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/servo_gripper_grasp_fsm_top.sv
// The input register takes each item and the result register loads its step result once it can advance.
// One item per cycle while the result side is not stalled.
// A stalled result holds the result register and a full input register; the input side stalls only when both are
// full and the held result is stalled.
// Reset (rst_n low, asynchronous) sets init mode, angle 120, no contact, contact time 0,
// the configuration registers to their defaults and both stages empty.
// Top level of the gripper grasp sequencer.
`default_nettype none

module servo_gripper_grasp_fsm_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire sggf_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output sggf_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_we,
    input  wire logic [sggf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sggf_pkg::CFG_W-1:0]     cfg_data
);
    import sggf_pkg::*;

    cfg_t       cfg;
    step_ctrl_t ctrl;
    in_item_t   item;
    out_item_t  result;
    logic       advance;

    sggf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sggf_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .advance  (advance),
        .ctrl     (ctrl),
        .item     (item)
    );

    sggf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    sggf_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (ctrl.item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

>>> rtl/sggf_checker.sv
// Port-level checks for the gripper grasp sequencer, bound to the top level.
`default_nettype none

module sggf_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_stall,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire sggf_pkg::out_item_t  out_data
);
    import sggf_pkg::*;

    // A stalled result stays and holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // The input side only stalls behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // The servo is only driven in the moving modes
    a_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.servo_write |->
            (out_data.mode == MODE_INIT || out_data.mode == MODE_CLOSE ||
             out_data.mode == MODE_POPEN))
        else $error("servo driven in a resting mode");

    // Each event comes with the mode it leads into
    a_event_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_res != EV_NONE |->
            (out_data.event_res == EV_INIT    && out_data.mode == MODE_IDLE) ||
            (out_data.event_res == EV_GRIPPED && out_data.mode == MODE_HOLD) ||
            (out_data.event_res == EV_PLACED  && out_data.mode == MODE_END))
        else $error("event and mode disagree");

    // An event step never drives the servo
    a_event_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_res != EV_NONE |-> !out_data.servo_write)
        else $error("servo driven on an event step");

endmodule

bind servo_gripper_grasp_fsm_top sggf_checker u_sggf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

>>> tb/grasp_step_checker.sv
// Channel monitor, step predictor and result comparison for the gripper grasp sequencer.
module grasp_step_checker
    import sggf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  in_item_t                   in_data,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    output int                         fail_count,
    output int                         outstanding,
    output int                         results_checked,
    output int                         grips_seen,
    output mode_t                      model_mode
);

    // Register copies, written alongside the block's own
    logic [LIMIT_BITS-1:0] set_limit;
    logic [15:0]           set_hold;
    logic [7:0]            set_open;
    logic [7:0]            set_close;

    // Sequencer state as the block should hold it
    mode_t       st_mode;
    logic [7:0]  st_angle;
    logic        st_contact;
    logic [31:0] st_contact_ms;

    out_item_t   due_results[$];
    out_item_t   want;

    // One control step: advances the state copy and returns the result it gives
    function automatic out_item_t grasp_step(in_item_t it);
        logic [7:0]  drive;
        logic        wr;
        event_t      ev;
        int          pos;
        logic [31:0] deadline;
        out_item_t   res;
        drive = '0;
        wr    = 1'b0;
        ev    = EV_NONE;
        case (st_mode)
            MODE_INIT:
                if (st_angle < set_open)
                begin
                    wr       = 1'b1;
                    drive    = st_angle;
                    st_angle = st_angle + 8'd1;
                end
                else
                begin
                    ev      = EV_INIT;
                    st_mode = MODE_IDLE;
                end
            MODE_IDLE:
                if (it.command == CMD_GRIP)
                    st_mode = MODE_CLOSE;
            MODE_CLOSE:
            begin
                // first firm contact latches its time
                if (it.pressure >= set_limit && !st_contact)
                begin
                    st_contact    = 1'b1;
                    st_contact_ms = it.now_ms;
                end
                pos = int'(st_angle) - 1;
                if (it.pressure < set_limit && pos > int'(set_close))
                begin
                    st_angle = st_angle - 8'd1;
                    wr       = 1'b1;
                    drive    = st_angle;
                end
                else
                begin
                    // wait measured from contact, sum wraps at 32 bits
                    deadline = st_contact_ms + 32'(set_hold);
                    if (it.now_ms > deadline)
                    begin
                        ev         = EV_GRIPPED;
                        st_mode    = MODE_HOLD;
                        st_contact = 1'b0;
                    end
                    if (pos <= int'(set_close))
                        st_angle = (set_close == ANGLE_MAX) ? ANGLE_MAX : set_close + 8'd1;
                    else
                        st_angle = st_angle - 8'd1;
                end
            end
            MODE_HOLD:
                if (it.command == CMD_RELEASE)
                    st_mode = MODE_POPEN;
                else if (it.pressure == '0)
                    st_mode = MODE_END;
            MODE_POPEN:
            begin
                pos      = int'(st_angle) + 1;
                st_angle = (pos > 255) ? ANGLE_MAX : st_angle + 8'd1;
                if (it.pressure != '0 && pos < int'(set_open))
                begin
                    wr    = 1'b1;
                    drive = st_angle;
                end
                else
                begin
                    ev      = EV_PLACED;
                    st_mode = MODE_END;
                end
            end
            MODE_END:
                if (it.command == CMD_RESET)
                    st_mode = MODE_INIT;
            default:
                ;
        endcase
        res.servo_angle = wr ? drive : st_angle;
        res.servo_write = wr;
        res.mode        = st_mode;
        res.event_res   = ev;
        return res;
    endfunction

    // Monitor: register writes, input transfers and result transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_limit       = PRESSURE_LIMIT_RST;
            set_hold        = HOLD_WAIT_MS_RST;
            set_open        = OPEN_ANGLE_RST;
            set_close       = CLOSE_LIMIT_RST;
            st_mode         = MODE_INIT;
            st_angle        = ANGLE_RST;
            st_contact      = 1'b0;
            st_contact_ms   = '0;
            due_results.delete();
            fail_count      = 0;
            results_checked = 0;
            grips_seen      = 0;
            outstanding     <= 0;
            model_mode      <= MODE_INIT;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PRESSURE_LIMIT: set_limit = cfg_data[LIMIT_BITS-1:0];
                    CFG_HOLD_WAIT_MS:   set_hold  = cfg_data[15:0];
                    CFG_OPEN_ANGLE:     set_open  = cfg_data[7:0];
                    CFG_CLOSE_LIMIT:    set_close = cfg_data[7:0];
                    default:            ;
                endcase
            end

            // compare before queuing, so a result cannot match its own input cycle
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (out_data.event_res == EV_GRIPPED)
                    grips_seen++;
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result transfer: angle %0d write %0b mode %0d event %0d",
                                 out_data.servo_angle, out_data.servo_write,
                                 out_data.mode, out_data.event_res);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_data.servo_angle !== want.servo_angle ||
                        out_data.servo_write !== want.servo_write ||
                        out_data.mode        !== want.mode ||
                        out_data.event_res   !== want.event_res)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("Result %0d mismatch: expected angle %0d write %0b mode %0d event %0d",
                                     results_checked, want.servo_angle, want.servo_write,
                                     want.mode, want.event_res);
                            $display("    got angle %0d write %0b mode %0d event %0d",
                                     out_data.servo_angle, out_data.servo_write,
                                     out_data.mode, out_data.event_res);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
                due_results.push_back(grasp_step(in_data));

            outstanding <= due_results.size();
            model_mode  <= st_mode;
        end
    end

endmodule

>>> tb/testbench.sv
// Stimulus, reset, watchdog and verdict for the gripper grasp sequencer.
module testbench;
    import sggf_pkg::*;

    localparam int STALL_LIMIT = 400;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int    fail_count;
    int    outstanding;
    int    results_checked;
    int    grips_seen;
    mode_t model_mode;

    // What the stimulus knows of the current settings
    int          cur_limit;
    int          cur_hold;
    logic [31:0] clock_ms;
    int          steps_sent;
    int          settings_used;
    logic        tx_quiet;
    logic        rx_quiet;
    int          idle_cycles;

    always #6 clk = ~clk;

    servo_gripper_grasp_fsm_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    grasp_step_checker u_grasp_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .grips_seen      (grips_seen),
        .model_mode      (model_mode)
    );

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    // Four register writes on consecutive edges; enable drops after the last
    task automatic write_settings(int lim, int hold_ms, int opn, int cls);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRESSURE_LIMIT;
        cfg_data  <= CFG_W'(lim);
        @(posedge clk);
        cfg_index <= CFG_HOLD_WAIT_MS;
        cfg_data  <= CFG_W'(hold_ms);
        @(posedge clk);
        cfg_index <= CFG_OPEN_ANGLE;
        cfg_data  <= CFG_W'(opn);
        @(posedge clk);
        cfg_index <= CFG_CLOSE_LIMIT;
        cfg_data  <= CFG_W'(cls);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = lim;
        cur_hold  = hold_ms;
        settings_used++;
    endtask

    // Sender gap, with quiet stretches redrawn every 20 steps
    task automatic wait_gap();
        int gap;
        if (steps_sent % 20 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic push_step(in_item_t it);
        in_data  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        steps_sent++;
    endtask

    task automatic send_fixed(int p, int c, logic [31:0] t);
        in_item_t it;
        it.pressure = PRESSURE_BITS'(p);
        it.command  = 3'(c);
        it.now_ms   = t;
        wait_gap();
        push_step(it);
    endtask

    // Mostly well-formed steps for the mode reached so far, some pure noise
    function automatic in_item_t next_item();
        in_item_t it;
        int       roll;
        roll        = $urandom_range(0, 99);
        clock_ms    = clock_ms + $urandom_range(0, cur_hold / 3 + 3);
        it.pressure = PRESSURE_BITS'($urandom);
        it.command  = 3'($urandom_range(0, 7));
        it.now_ms   = clock_ms;
        if (roll < 10)
        begin
            it.now_ms = $urandom;
            return it;
        end
        case (model_mode)
            MODE_IDLE:
                if (roll < 75)
                    it.command = CMD_GRIP;
            MODE_CLOSE:
                if (roll < 30)
                    it.pressure = PRESSURE_BITS'($urandom_range(cur_limit, 1023));
                else if (cur_limit > 0)
                    it.pressure = PRESSURE_BITS'($urandom_range(0, cur_limit - 1));
            MODE_HOLD:
                if (roll < 45)
                    it.command = CMD_RELEASE;
                else if (roll < 65)
                    it.pressure = '0;
            MODE_POPEN:
                if (roll < 25)
                    it.pressure = '0;
            MODE_END:
                if (roll < 60)
                    it.command = CMD_RESET;
            default:
                ;
        endcase
        return it;
    endfunction

    // Let every outstanding result arrive before touching the registers
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(int lim, int hold_ms, int opn, int cls, int steps);
        drain();
        write_settings(lim, hold_ms, opn, cls);
        // a third of the phases start just short of the time wrap
        if ($urandom_range(0, 2) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * hold_ms + 100);
        else
            clock_ms = $urandom;
        repeat (steps)
        begin
            wait_gap();
            push_step(next_item());
        end
    endtask

    // Result side: stall for a drawn number of cycles before each transfer
    initial
    begin : receiver
        int stall_len;
        int served;
        served = 0;
        @(posedge rst_n);
        forever
        begin
            if (served % 20 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall_len = rx_quiet ? 0 : $urandom_range(0, 9);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            served++;
        end
    end

    initial
    begin : stimulus
        steps_sent    = 0;
        settings_used = 0;
        tx_quiet      = 1'b0;
        cur_limit     = 512;
        cur_hold      = 8000;
        clock_ms      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short opening, contact at the top limit, zero wait, full cycle
        write_settings(1023, 0, 123, 119);
        send_fixed(0, 4, 32'd0);
        send_fixed(1023, 7, 32'd1);
        send_fixed(512, 2, 32'd2);
        send_fixed(0, 0, 32'd3);              // opening done, initialised
        send_fixed(100, 0, 32'd4);
        send_fixed(100, CMD_GRIP, 32'd5);
        send_fixed(1023, 5, 32'hFFFF_FFF0);   // contact at the limit, timer not yet past
        send_fixed(1022, 6, 32'hFFFF_FFF1);
        send_fixed(0, 0, 32'hFFFF_FFF2);
        send_fixed(5, 0, 32'hFFFF_FFFF);      // floor reached, gripped
        send_fixed(1, 0, 32'd7);
        send_fixed(300, CMD_RELEASE, 32'd8);
        send_fixed(1023, 0, 32'd9);
        send_fixed(1023, 3, 32'd10);
        send_fixed(1023, 0, 32'd11);          // open angle reached, placed
        send_fixed(0, CMD_GRIP, 32'd12);
        send_fixed(0, CMD_RESET, 32'd13);
        send_fixed(0, 0, 32'd14);             // angle already at the open angle
        send_fixed(0, CMD_GRIP, 32'd15);
        // floor with no new contact: old contact time still governs the timer
        send_fixed(0, 0, 32'd16);
        send_fixed(0, 0, 32'd17);
        send_fixed(0, 0, 32'd18);
        send_fixed(0, 0, 32'd19);
        send_fixed(0, 0, 32'hFFFF_FFFF);
        send_fixed(0, 0, 32'd20);             // force gone while holding

        // Random: limit, wait and floor extremes, then defaults and random settings
        run_phase(0, 65535, 1, 0, 80);
        run_phase(1023, 0, 180, 179, 80);
        run_phase(300, 2000, 140, 120, 80);
        run_phase(700, 500, 60, 255, 70);     // floor clamp and opening saturate at 255
        run_phase(512, 8000, 180, 100, 90);
        repeat (2)
            run_phase($urandom_range(0, 1023), $urandom_range(0, 4000),
                      $urandom_range(1, 180), $urandom_range(0, 179), 60);

        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d control steps under %0d register settings, checked %0d results.",
                 steps_sent, settings_used, results_checked);
        $display("Objects gripped %0d times; %0d result failures.", grips_seen, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
